// ===== src/assert_macros.svh =====
// Shared assertion forms for the RTL in this folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_AT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When cond holds, check res in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, res, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (res)) else $error(msg);

`endif

// ===== src/drdt_pkg.sv =====
package drdt_pkg;

  localparam int CntWidth   = 32;
  localparam int AddrWidth  = 24;
  localparam int DataWidth  = 32;
  localparam int MsgWidth   = 16;
  localparam int MapBytes   = 17;
  localparam int Lanes      = DataWidth / 8;
  localparam int PaddrWidth = 3;

  localparam logic [AddrWidth-1:0] BaseReset = 24'h11E000;

  localparam logic [1:0] ModeTick  = 2'd0;
  localparam logic [1:0] ModeRead  = 2'd1;
  localparam logic [1:0] ModeWrite = 2'd2;
  localparam logic [1:0] ModeAck   = 2'd3;

  localparam logic [1:0] SizeByte = 2'd0;
  localparam logic [1:0] SizeWord = 2'd1;

  localparam logic [MsgWidth-1:0] MsgNone   = 16'h0000;
  localparam logic [MsgWidth-1:0] MsgTimer0 = 16'h0001;
  localparam logic [MsgWidth-1:0] MsgTimer1 = 16'h1001;

  // control byte bit positions
  localparam int CtrlEn0 = 0;
  localparam int CtrlIe0 = 1;
  localparam int CtrlEn1 = 3;
  localparam int CtrlIe1 = 4;

  typedef logic [CntWidth-1:0]  cnt_t;
  typedef logic [DataWidth-1:0] word_t;
  typedef logic [AddrWidth-1:0] addr_t;
  typedef logic [7:0]           byte_t;

  typedef struct packed {
    cnt_t count;
    logic pend;
  } tick_res_t;

  // Count down by n; on borrow reload once with the borrow folded in.
  function automatic tick_res_t count_down(cnt_t old, cnt_t reload, cnt_t n,
                                           logic int_en, logic pend);
    logic [CntWidth:0] diff;
    tick_res_t         r;
    diff    = {1'b0, old} - {1'b0, n};
    r.count = diff[CntWidth-1:0];
    r.pend  = pend;
    if (diff[CntWidth]) begin
      r.count = reload + diff[CntWidth-1:0] + cnt_t'(1);
      r.pend  = int_en;
    end
    return r;
  endfunction

endpackage

// ===== src/dual_reload_down_timer_top.sv =====
// Channel   Direction  Handshake            Word
// in        input      in_valid/in_stall    mode, address, access_size, write_data, tick_count
// out       output     out_valid/out_stall  read_data, irq_pending, irq_message
// cfg       input      APB psel/penable     base_address at byte addresses 0 to 3
//
// A word passes through the input register and then the result register;
// a new word is taken every cycle while in_stall is low.
// The per-word path is the byte-lane decode plus a counter subtract and reload add per timer.
// Synchronous reset clears all timer state and both valid flags.
// A stall on the output holds the result and then the input register; in_stall
// rises only while both registers are full.
`include "assert_macros.svh"

module dual_reload_down_timer_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [drdt_pkg::PaddrWidth-1:0]   paddr,
  input  logic [drdt_pkg::DataWidth-1:0]    pwdata,
  output logic [drdt_pkg::DataWidth-1:0]    prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        mode,
  input  logic [drdt_pkg::AddrWidth-1:0]    address,
  input  logic [1:0]                        access_size,
  input  logic [drdt_pkg::DataWidth-1:0]    write_data,
  input  logic [drdt_pkg::DataWidth-1:0]    tick_count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [drdt_pkg::DataWidth-1:0]    read_data,
  output logic                              irq_pending,
  output logic [drdt_pkg::MsgWidth-1:0]     irq_message
);

  drdt_pkg::addr_t base_address;
  drdt_pkg::cnt_t  count_zero;
  drdt_pkg::cnt_t  reload_zero;
  drdt_pkg::cnt_t  count_one;
  drdt_pkg::cnt_t  reload_one;
  logic [7:0]      control_bits;
  logic            pending_zero;
  logic            pending_one;

  logic             slot_valid;
  logic [1:0]       slot_mode;
  drdt_pkg::addr_t  slot_address;
  logic [1:0]       slot_size;
  drdt_pkg::word_t  slot_wdata;
  drdt_pkg::cnt_t   slot_ticks;

  logic advance;
  logic accept;
  logic cfg_write;

  drdt_pkg::cnt_t  count_zero_next;
  drdt_pkg::cnt_t  reload_zero_next;
  drdt_pkg::cnt_t  count_one_next;
  drdt_pkg::cnt_t  reload_one_next;
  logic [7:0]      control_bits_next;
  logic            pending_zero_next;
  logic            pending_one_next;
  drdt_pkg::word_t read_data_next;
  logic            irq_pending_next;
  logic [drdt_pkg::MsgWidth-1:0] irq_message_next;

  drdt_pkg::byte_t   map_cur  [drdt_pkg::MapBytes];
  drdt_pkg::byte_t   map_new  [drdt_pkg::MapBytes];
  drdt_pkg::word_t   words_new [4];
  drdt_pkg::addr_t   delta;
  drdt_pkg::tick_res_t tick_zero;
  drdt_pkg::tick_res_t tick_one;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && !paddr[2];
  assign prdata    = paddr[2] ? '0 : drdt_pkg::word_t'(base_address);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= drdt_pkg::BaseReset;
    end else if (cfg_write) begin
      base_address <= pwdata[drdt_pkg::AddrWidth-1:0];
    end
  end

  // handshake: the input register drains whenever the result register can load
  assign advance  = slot_valid && (!out_valid || !out_stall);
  assign in_stall = slot_valid && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (accept) begin
      slot_valid <= 1'b1;
    end else if (advance) begin
      slot_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_mode    <= mode;
      slot_address <= address;
      slot_size    <= access_size;
      slot_wdata   <= write_data;
      slot_ticks   <= tick_count[drdt_pkg::CntWidth-1:0];
    end
  end

  // byte view of the register map
  assign delta = slot_address - base_address;

  always_comb begin
    drdt_pkg::word_t words_cur [4];
    drdt_pkg::addr_t lane_off [drdt_pkg::Lanes];
    logic            lane_en  [drdt_pkg::Lanes];
    words_cur[0] = drdt_pkg::word_t'(count_zero);
    words_cur[1] = drdt_pkg::word_t'(reload_zero);
    words_cur[2] = drdt_pkg::word_t'(count_one);
    words_cur[3] = drdt_pkg::word_t'(reload_one);
    for (int j = 0; j < drdt_pkg::MapBytes - 1; j++) begin
      map_cur[j] = words_cur[j >> 2][(j & 3) * 8 +: 8];
    end
    map_cur[drdt_pkg::MapBytes-1] = control_bits;
    map_new        = map_cur;
    read_data_next = '0;
    for (int i = 0; i < drdt_pkg::Lanes; i++) begin
      lane_off[i] = delta + drdt_pkg::addr_t'(i);
      lane_en[i]  = (i == 0) || (i == 1 && slot_size != drdt_pkg::SizeByte) ||
                    (i >= 2 && slot_size != drdt_pkg::SizeByte &&
                     slot_size != drdt_pkg::SizeWord);
      if (lane_en[i] && lane_off[i] < drdt_pkg::addr_t'(drdt_pkg::MapBytes)) begin
        if (slot_mode == drdt_pkg::ModeRead) begin
          read_data_next[i*8 +: 8] = map_cur[lane_off[i][4:0]];
        end
        if (slot_mode == drdt_pkg::ModeWrite) begin
          map_new[lane_off[i][4:0]] = slot_wdata[i*8 +: 8];
        end
      end
    end
    for (int r = 0; r < 4; r++) begin
      words_new[r] = {map_new[4*r+3], map_new[4*r+2], map_new[4*r+1], map_new[4*r]};
    end
  end

  assign tick_zero = drdt_pkg::count_down(count_zero, reload_zero, slot_ticks,
                                          control_bits[drdt_pkg::CtrlIe0], pending_zero);
  assign tick_one  = drdt_pkg::count_down(count_one, reload_one, slot_ticks,
                                          control_bits[drdt_pkg::CtrlIe1], pending_one);

  always_comb begin
    count_zero_next   = count_zero;
    reload_zero_next  = reload_zero;
    count_one_next    = count_one;
    reload_one_next   = reload_one;
    control_bits_next = control_bits;
    pending_zero_next = pending_zero;
    pending_one_next  = pending_one;
    case (slot_mode)
      drdt_pkg::ModeTick: begin
        if (control_bits[drdt_pkg::CtrlEn0]) begin
          count_zero_next   = tick_zero.count;
          pending_zero_next = tick_zero.pend;
        end
        if (control_bits[drdt_pkg::CtrlEn1]) begin
          count_one_next   = tick_one.count;
          pending_one_next = tick_one.pend;
        end
      end
      drdt_pkg::ModeWrite: begin
        // drop bits above the counter width
        count_zero_next   = drdt_pkg::cnt_t'(words_new[0]);
        reload_zero_next  = drdt_pkg::cnt_t'(words_new[1]);
        count_one_next    = drdt_pkg::cnt_t'(words_new[2]);
        reload_one_next   = drdt_pkg::cnt_t'(words_new[3]);
        control_bits_next = map_new[drdt_pkg::MapBytes-1];
      end
      drdt_pkg::ModeAck: begin
        if (pending_zero) begin
          pending_zero_next = 1'b0;
        end else begin
          pending_one_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // report the interrupt state after this word, timer 0 first
  always_comb begin
    irq_pending_next = 1'b0;
    irq_message_next = drdt_pkg::MsgNone;
    if (control_bits_next[drdt_pkg::CtrlIe0] && pending_zero_next) begin
      irq_pending_next = 1'b1;
      irq_message_next = drdt_pkg::MsgTimer0;
    end else if (control_bits_next[drdt_pkg::CtrlIe1] && pending_one_next) begin
      irq_pending_next = 1'b1;
      irq_message_next = drdt_pkg::MsgTimer1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_zero   <= '0;
      reload_zero  <= '0;
      count_one    <= '0;
      reload_one   <= '0;
      control_bits <= '0;
      pending_zero <= 1'b0;
      pending_one  <= 1'b0;
    end else if (advance) begin
      count_zero   <= count_zero_next;
      reload_zero  <= reload_zero_next;
      count_one    <= count_one_next;
      reload_one   <= reload_one_next;
      control_bits <= control_bits_next;
      pending_zero <= pending_zero_next;
      pending_one  <= pending_one_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data   <= read_data_next;
      irq_pending <= irq_pending_next;
      irq_message <= irq_message_next;
    end
  end

  `ASSERT_AT(a_irq_consistent, clk, rst,
             !out_valid || (irq_pending == (irq_message != drdt_pkg::MsgNone)),
             "irq_pending disagrees with irq_message")
  `ASSERT_AT(a_stall_only_full, clk, rst,
             !in_stall || (slot_valid && out_valid),
             "input stalled while a register is free")
  `ASSERT_NEXT(a_ack_clears_zero, clk, rst,
               advance && slot_mode == drdt_pkg::ModeAck && pending_zero,
               !pending_zero, "acknowledge left timer 0 pending")
  `ASSERT_NEXT(a_disabled_holds, clk, rst,
               advance && slot_mode == drdt_pkg::ModeTick &&
               !control_bits[drdt_pkg::CtrlEn0],
               $stable(count_zero), "disabled timer 0 counted")

endmodule
